@@ design/msdrt_pkg.sv @@
// Shared types, codes and time arithmetic for the multi-slot delay/repeat timer.
// No dependencies; imported by the top level and msdrt_slot_update.
`timescale 1ns / 1ps
`default_nettype none

package msdrt_pkg;

    localparam int SLOTS       = 16;
    localparam int TIME_BITS   = 32;
    localparam int MAX_RESULTS = 16;

    localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int REP_BITS   = $clog2(MAX_RESULTS + 1);
    localparam int DUR_BITS   = 31;
    localparam int COUNT_BITS = 24;
    localparam int SUB_BITS   = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;

    // field widths on the ports
    localparam int CMD_BITS     = 2;
    localparam int KIND_BITS    = 3;
    localparam int IN_SLOT_BITS = 4;

    localparam logic [CMD_BITS-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_CREATE  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_DESTROY = 2'd2;

    localparam logic [KIND_BITS-1:0] KIND_CREATED  = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_REJECTED = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_DESTROY  = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_FIRED    = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_NONE     = 3'd4;

    typedef logic signed [TIME_BITS-1:0] time_t;

    localparam time_t TIME_MIN = {1'b1, {(TIME_BITS-1){1'b0}}};
    localparam time_t TIME_MAX = {1'b0, {(TIME_BITS-1){1'b1}}};

    // per-slot record held in the main slot memory
    typedef struct packed {
        logic [COUNT_BITS-1:0] count_left;
        time_t                 gap_length;
        time_t                 delay_left;
    } slot_rec_t;

    localparam int REC_BITS = $bits(slot_rec_t);

    typedef struct packed {
        logic fire;
        logic ended;
    } upd_status_t;

    // a - d, clamped at the signed minimum
    function automatic time_t sat_sub(input time_t a, input logic [DUR_BITS-1:0] d);
        logic signed [SUB_BITS-1:0] diff;
        logic signed [SUB_BITS-1:0] floor_v;
        diff    = SUB_BITS'(a) - $signed(SUB_BITS'(d));
        floor_v = SUB_BITS'(TIME_MIN);
        if (diff < floor_v) begin
            return TIME_MIN;
        end
        return TIME_BITS'(diff);
    endfunction

    // unsigned duration into signed time, clamped at the signed maximum
    function automatic time_t load_time(input logic [DUR_BITS-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        if (wide > 64'(TIME_MAX)) begin
            return TIME_MAX;
        end
        return TIME_BITS'(wide);
    endfunction

endpackage

`default_nettype wire

@@ design/multi_slot_delay_repeat_timer.sv @@
// Top level of the multi-slot delay/repeat timer: command decode, slot sweep, result queue.
// Depends on msdrt_pkg, msdrt_ram and msdrt_slot_update.
`timescale 1ns / 1ps
`default_nettype none

// Table of SLOTS timers. Create and destroy each give one result item. A tick
// is accepted while the slots marked for destroy are freed; then each slot in
// turn gets a read-modify-write of the slot memories (read issued ahead of the
// update, written back as the next slot is read), and a flush state releases
// the final result. Backpressure on m_ stalls the sweep. Each firing gives a
// FIRED item in slot order (at most MAX_RESULTS reported); a tick with no firing
// gives one NONE item. Timer values live in two RAMs; the four flag bits per slot
// are flops cleared by reset. Times are signed TIME_BITS microsecond counts.
module multi_slot_delay_repeat_timer
    import msdrt_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input items
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,  // slot[3:0], repeat_mode[4], delay_us[35:5],
                                        // gap_us[66:36], repeat_count[90:67],
                                        // delta_us[121:91], zero fill
    input  wire logic [1:0]   s_tuser,  // cmd[1:0]
    // result items
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [7:0]        m_tdata,  // out_slot[3:0], zero fill
    output logic [2:0]        m_tuser,  // kind[2:0]
    output logic              m_tlast   // last
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    // input field unpack
    logic [CMD_BITS-1:0]     in_cmd;
    logic [IN_SLOT_BITS-1:0] in_slot;
    logic                    in_mode;
    logic [DUR_BITS-1:0]     in_delay;
    logic [DUR_BITS-1:0]     in_gap;
    logic [COUNT_BITS-1:0]   in_count;
    logic [DUR_BITS-1:0]     in_delta;

    assign in_cmd   = s_tuser;
    assign in_slot  = s_tdata[3:0];
    assign in_mode  = s_tdata[4];
    assign in_delay = s_tdata[35:5];
    assign in_gap   = s_tdata[66:36];
    assign in_count = s_tdata[90:67];
    assign in_delta = s_tdata[121:91];

    // control state
    logic [1:0]           state_reg, state_next;
    logic [SLOT_BITS-1:0] idx_reg, idx_next;
    logic [REP_BITS-1:0]  rep_cnt_reg, rep_cnt_next;
    logic                 hold_valid_reg, hold_valid_next;
    logic                 m_valid_reg, m_valid_next;
    logic [SLOTS-1:0]     active_reg, active_next;
    logic [SLOTS-1:0]     ended_reg, ended_next;
    logic [SLOTS-1:0]     pending_reg, pending_next;
    logic [SLOTS-1:0]     repeat_reg, repeat_next;

    // payload
    logic [DUR_BITS-1:0]     delta_reg, delta_next;
    logic [SLOT_BITS-1:0]    hold_slot_reg, hold_slot_next;
    logic [KIND_BITS-1:0]    m_kind_reg, m_kind_next;
    logic [IN_SLOT_BITS-1:0] m_slot_reg, m_slot_next;
    logic                    m_last_reg, m_last_next;

    // memory ports
    logic                 rec_we, gap_we;
    logic [SLOT_BITS-1:0] waddr, raddr;
    slot_rec_t            rec_wdata, rec_rdata, rec_upd;
    time_t                gap_wdata, gap_rdata, gap_upd;
    upd_status_t          upd_status;

    logic                 out_free;
    logic                 in_acc;
    logic                 in_range;
    logic [SLOT_BITS-1:0] cslot;
    logic                 live;
    logic                 report;
    logic                 stall;

    msdrt_ram #(.WIDTH(REC_BITS), .DEPTH(SLOTS)) u_rec_ram (
        .clk   (aclk),
        .we    (rec_we),
        .waddr (waddr),
        .wdata (rec_wdata),
        .raddr (raddr),
        .rdata (rec_rdata)
    );

    msdrt_ram #(.WIDTH(TIME_BITS), .DEPTH(SLOTS)) u_gap_ram (
        .clk   (aclk),
        .we    (gap_we),
        .waddr (waddr),
        .wdata (gap_wdata),
        .raddr (raddr),
        .rdata (gap_rdata)
    );

    msdrt_slot_update u_update (
        .rec          (rec_rdata),
        .gap_left     (gap_rdata),
        .is_repeat    (repeat_reg[idx_reg]),
        .delta        (delta_reg),
        .rec_new      (rec_upd),
        .gap_left_new (gap_upd),
        .status       (upd_status)
    );

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        rep_cnt_next    = rep_cnt_reg;
        hold_valid_next = hold_valid_reg;
        active_next     = active_reg;
        ended_next      = ended_reg;
        pending_next    = pending_reg;
        repeat_next     = repeat_reg;
        delta_next      = delta_reg;
        hold_slot_next  = hold_slot_reg;
        m_kind_next     = m_kind_reg;
        m_slot_next     = m_slot_reg;
        m_last_next     = m_last_reg;

        out_free     = !m_valid_reg || m_tready;
        s_tready     = (state_reg == ST_IDLE) && out_free;
        in_acc       = s_tvalid && s_tready;
        m_valid_next = m_valid_reg && !m_tready;

        in_range = (32'(in_slot) < SLOTS);
        cslot    = SLOT_BITS'(in_slot);
        live     = active_reg[idx_reg] && !ended_reg[idx_reg];
        report   = live && upd_status.fire && (rep_cnt_reg < REP_BITS'(MAX_RESULTS));
        stall    = report && hold_valid_reg && !out_free;

        rec_we    = 1'b0;
        gap_we    = 1'b0;
        waddr     = idx_reg;
        raddr     = idx_reg;
        rec_wdata = rec_upd;
        gap_wdata = gap_upd;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (in_cmd)
                        CMD_CREATE: begin
                            m_valid_next = 1'b1;
                            m_slot_next  = in_slot;
                            m_last_next  = 1'b1;
                            if (!in_range || (active_reg[cslot] && !ended_reg[cslot])) begin
                                m_kind_next = KIND_REJECTED;
                            end else begin
                                m_kind_next = KIND_CREATED;
                                waddr       = cslot;
                                rec_we      = 1'b1;
                                rec_wdata.count_left = in_count;
                                rec_wdata.gap_length = load_time(in_gap);
                                rec_wdata.delay_left = load_time(in_delay);
                                // first arming clears gap_left; re-arm keeps it
                                gap_we    = !active_reg[cslot];
                                gap_wdata = '0;
                                active_next[cslot] = 1'b1;
                                ended_next[cslot]  = 1'b0;
                                repeat_next[cslot] = in_mode;
                            end
                        end
                        CMD_DESTROY: begin
                            m_valid_next = 1'b1;
                            m_kind_next  = KIND_DESTROY;
                            m_slot_next  = in_slot;
                            m_last_next  = 1'b1;
                            if (in_range && active_reg[cslot]) begin
                                pending_next[cslot] = 1'b1;
                            end
                        end
                        CMD_TICK: begin
                            // free marked slots before the sweep
                            active_next     = active_reg & ~pending_reg;
                            ended_next      = ended_reg & ~pending_reg;
                            pending_next    = '0;
                            delta_next      = in_delta;
                            idx_next        = '0;
                            raddr           = '0;
                            rep_cnt_next    = '0;
                            hold_valid_next = 1'b0;
                            state_next      = ST_SWEEP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                if (!stall) begin
                    if (live) begin
                        rec_we              = 1'b1;
                        gap_we              = 1'b1;
                        ended_next[idx_reg] = upd_status.ended;
                    end
                    if (report) begin
                        // a newer firing releases the held one as not-last
                        if (hold_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_kind_next  = KIND_FIRED;
                            m_slot_next  = IN_SLOT_BITS'(hold_slot_reg);
                            m_last_next  = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_slot_next  = idx_reg;
                        rep_cnt_next    = rep_cnt_reg + REP_BITS'(1);
                    end
                    if (idx_reg == SLOT_BITS'(SLOTS - 1)) begin
                        state_next = ST_FLUSH;
                    end else begin
                        idx_next = idx_reg + SLOT_BITS'(1);
                        raddr    = idx_reg + SLOT_BITS'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_last_next     = 1'b1;
                    m_kind_next     = hold_valid_reg ? KIND_FIRED : KIND_NONE;
                    m_slot_next     = hold_valid_reg ? IN_SLOT_BITS'(hold_slot_reg) : '0;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            rep_cnt_reg    <= '0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            active_reg     <= '0;
            ended_reg      <= '0;
            pending_reg    <= '0;
            repeat_reg     <= '0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            rep_cnt_reg    <= rep_cnt_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
            active_reg     <= active_next;
            ended_reg      <= ended_next;
            pending_reg    <= pending_next;
            repeat_reg     <= repeat_next;
        end
    end

    always_ff @(posedge aclk) begin
        delta_reg     <= delta_next;
        hold_slot_reg <= hold_slot_next;
        m_kind_reg    <= m_kind_next;
        m_slot_reg    <= m_slot_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, m_slot_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

@@ design/msdrt_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module msdrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ design/msdrt_slot_update.sv @@
// Per-slot tick update: firing test, count/gap/delay bookkeeping.
// Depends on msdrt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msdrt_slot_update
    import msdrt_pkg::*;
(
    input  wire slot_rec_t              rec,
    input  wire time_t                  gap_left,
    input  wire logic                   is_repeat,
    input  wire logic [DUR_BITS-1:0]    delta,
    output slot_rec_t                   rec_new,
    output time_t                       gap_left_new,
    output upd_status_t                 status
);

    logic                  used_up;
    logic                  rep_fire;
    logic [COUNT_BITS-1:0] cnt1;
    time_t                 gap1;

    always_comb begin
        used_up  = (rec.delay_left <= 0);
        rep_fire = (rec.count_left != '0) && used_up && (gap_left <= 0);
        cnt1     = rep_fire ? rec.count_left - COUNT_BITS'(1) : rec.count_left;
        gap1     = rep_fire ? rec.gap_length : gap_left;

        rec_new.gap_length = rec.gap_length;
        rec_new.delay_left = sat_sub(rec.delay_left, delta);

        if (is_repeat) begin
            rec_new.count_left = cnt1;
            gap_left_new       = used_up ? sat_sub(gap1, delta) : gap1;
            status.fire        = rep_fire;
            status.ended       = (cnt1 == '0);
        end else begin
            rec_new.count_left = rec.count_left;
            gap_left_new       = gap_left;
            status.fire        = used_up;
            status.ended       = used_up;
        end
    end

endmodule

`default_nettype wire
